// ----- sv/three_level_priority_queue_unit_macros.svh -----
// Assertion macros used by the queue unit controller RTL.
// ASSERT_IMPL checks that cons holds in the same cycle as ante.
// ASSERT_NEXT checks that cons holds in the cycle after ante.
`ifndef THREE_LEVEL_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- sv/tlpq_pkg.sv -----
`default_nettype none
package tlpq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 8;
   localparam int DEFAULT_QUEUE_COUNT = 3;

   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int QUSED_W  = 2;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_INSERTED = 2'd0;
   localparam status_type ST_FULL     = 2'd1;
   localparam status_type ST_REMOVED  = 2'd2;
   localparam status_type ST_EMPTY    = 2'd3;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic ins;   // Insert transaction accepted this cycle.
      logic rem;   // Remove transaction accepted this cycle.
      logic fin;   // Read data of a removal is ready; load the result.
   } cmd_type;

endpackage
`default_nettype wire

// ----- sv/three_level_priority_queue_unit.sv -----
// Channel   Direction  Handshake               Payload
// req_      in         req_tvalid/req_tready   tuser: req_type; tdata: value_in
// rsp_      out        rsp_tvalid/rsp_tready   tuser: status; tdata: value_out, queue_used
//
// An insert transaction's result is registered at the accepting edge.
// A remove transaction's result passes the registered slot RAM read port, then S_READ.
// Reset is synchronous and active high; the pointers clear at once and no clearing pass runs.
// A new request is accepted while a result waits, provided that result is taken in the
// same cycle; otherwise the request side stalls until the result side drains.
// The request side also stalls while a removal sits in S_READ after its slot RAM read.
`default_nettype none
module three_level_priority_queue_unit
   import tlpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   parameter int QUEUE_COUNT = DEFAULT_QUEUE_COUNT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value_in
   input  wire logic [0:0]  req_tuser,   // [0] req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata,   // [31:0] value_out, [33:32] queue_used, zero above
   output logic      [1:0]  rsp_tuser    // [1:0] status
);

   // Commands from the controller tell the datapath which transaction is in flight.
   cmd_type            cmd;
   status_type         status;
   logic [DATA_W-1:0]  value_out;
   logic [QUSED_W-1:0] queue_used;

   // The controller owns the handshake and the result-valid flag.
   tlpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_tuser[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // The datapath holds the pointers, the slot RAM and the result register.
   tlpq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .QUEUE_COUNT (QUEUE_COUNT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .value_in   (req_tdata),
      .status     (status),
      .value_out  (value_out),
      .queue_used (queue_used)
   );

   // Results are packed with value_out in the low bits, then queue_used, then zero fill.
   assign rsp_tdata = {6'b0, queue_used, value_out};
   assign rsp_tuser = status;

endmodule
`default_nettype wire

// ----- sv/tlpq_ram.sv -----
`default_nettype none
module tlpq_ram
   import tlpq_pkg::*;
#(
   parameter int WIDTH = DATA_W,
   parameter int DEPTH = DEFAULT_QUEUE_DEPTH * DEFAULT_QUEUE_COUNT
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- sv/tlpq_ctrl.sv -----
`default_nettype none
`include "three_level_priority_queue_unit_macros.svh"
module tlpq_ctrl
   import tlpq_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   input  wire logic req_type,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   output cmd_type   cmd
);

   localparam logic [0:0] S_IDLE = 1'b0;
   localparam logic [0:0] S_READ = 1'b1;

   logic [0:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   // A new transaction is taken only when the result register is free or drains now.
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd.ins  = accept && (req_type == REQ_INSERT);
      cmd.rem  = accept && (req_type == REQ_REMOVE);
      cmd.fin  = (state_ff == S_READ);
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.rem) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (cmd.ins || cmd.fin) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `ASSERT_NEXT(a_rem_then_fin, clock, reset, cmd.rem, cmd.fin, "removal did not finish next cycle")
   `ASSERT_NEXT(a_ins_gives_rsp, clock, reset, cmd.ins, rsp_tvalid, "insert gave no result")
   `ASSERT_NEXT(a_fin_gives_rsp, clock, reset, cmd.fin, rsp_tvalid, "removal gave no result")
   `ASSERT_IMPL(a_fin_from_rem, clock, reset, cmd.fin, $past(cmd.rem), "finish without removal")

endmodule
`default_nettype wire

// ----- sv/tlpq_dp.sv -----
`default_nettype none
module tlpq_dp
   import tlpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   parameter int QUEUE_COUNT = DEFAULT_QUEUE_COUNT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   input  wire logic [DATA_W-1:0]  value_in,
   output status_type              status,
   output logic      [DATA_W-1:0]  value_out,
   output logic      [QUSED_W-1:0] queue_used
);

   localparam int SLOTS = QUEUE_COUNT * QUEUE_DEPTH;
   localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int QW    = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
   localparam int PW    = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] DEPTH_P = PW'(QUEUE_DEPTH);

   logic [PW-1:0]      head_ff [QUEUE_COUNT];
   logic [PW-1:0]      tail_ff [QUEUE_COUNT];
   status_type         pend_status_ff;
   logic [QUSED_W-1:0] pend_queue_ff;
   status_type         out_status_ff;
   logic [DATA_W-1:0]  out_value_ff;
   logic [QUSED_W-1:0] out_queue_ff;

   logic [QW-1:0]      ins_sel, rem_sel;
   logic               ins_found, rem_found;
   logic               all_empty_after;
   logic [PW-1:0]      head_next;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [DATA_W-1:0]  rd_data;

   // Lowest-numbered queue that is not full, and lowest that is not empty.
   always_comb begin
      ins_sel   = '0;
      ins_found = 1'b0;
      rem_sel   = '0;
      rem_found = 1'b0;
      for (int k = QUEUE_COUNT - 1; k >= 0; k--) begin
         if (tail_ff[k] != DEPTH_P) begin
            ins_sel   = QW'(k);
            ins_found = 1'b1;
         end
         if (head_ff[k] != tail_ff[k]) begin
            rem_sel   = QW'(k);
            rem_found = 1'b1;
         end
      end
   end

   always_comb begin
      all_empty_after = 1'b1;
      for (int j = 0; j < QUEUE_COUNT; j++) begin
         head_next = (QW'(j) == rem_sel) ? head_ff[j] + PW'(1) : head_ff[j];
         if (head_next != tail_ff[j]) begin
            all_empty_after = 1'b0;
         end
      end
   end

   assign wr_addr = AW'(AW'(ins_sel) * AW'(QUEUE_DEPTH)) + AW'(tail_ff[ins_sel]);
   assign rd_addr = AW'(AW'(rem_sel) * AW'(QUEUE_DEPTH)) + AW'(head_ff[rem_sel]);

   tlpq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (cmd.ins && ins_found),
      .wr_addr (wr_addr),
      .wr_data (value_in),
      .rd_en   (cmd.rem && rem_found),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QUEUE_COUNT; k++) begin
            head_ff[k] <= '0;
            tail_ff[k] <= '0;
         end
      end else if (cmd.ins && ins_found) begin
         tail_ff[ins_sel] <= tail_ff[ins_sel] + PW'(1);
      end else if (cmd.rem && rem_found) begin
         if (all_empty_after) begin
            for (int k = 0; k < QUEUE_COUNT; k++) begin
               head_ff[k] <= '0;
               tail_ff[k] <= '0;
            end
         end else begin
            head_ff[rem_sel] <= head_ff[rem_sel] + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins) begin
         out_status_ff <= ins_found ? ST_INSERTED : ST_FULL;
         out_value_ff  <= '0;
         out_queue_ff  <= ins_found ? QUSED_W'(ins_sel) : '0;
      end else if (cmd.fin) begin
         out_status_ff <= pend_status_ff;
         out_value_ff  <= (pend_status_ff == ST_REMOVED) ? rd_data : '0;
         out_queue_ff  <= pend_queue_ff;
      end
      if (cmd.rem) begin
         pend_status_ff <= rem_found ? ST_REMOVED : ST_EMPTY;
         pend_queue_ff  <= rem_found ? QUSED_W'(rem_sel) : '0;
      end
   end

   assign status     = out_status_ff;
   assign value_out  = out_value_ff;
   assign queue_used = out_queue_ff;

endmodule
`default_nettype wire

// ----- dv/tlpq_result_checker.sv -----
`timescale 1ns / 1ps
module tlpq_result_checker
   import tlpq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,
   input  wire logic [0:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,
   output int               error_count,
   output int               pending_count
);

   localparam int DEPTH = DEFAULT_QUEUE_DEPTH;
   localparam int LANES = DEFAULT_QUEUE_COUNT;

   typedef struct packed {
      status_type           status;
      logic [DATA_W-1:0]    value_out;
      logic [QUSED_W-1:0]   queue_used;
   } outcome_type;

   // Shadow copy of the three linear queues.
   logic [DATA_W-1:0] lane_slots [LANES][DEPTH];
   int unsigned       lane_head  [LANES];
   int unsigned       lane_tail  [LANES];
   outcome_type       expected_outcomes [$];
   int                mismatches = 0;

   task automatic report_mismatch(input string what, input logic [39:0] got,
                                  input logic [39:0] want);
      $display("%0t ns: response %s mismatch: got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   // Applies one request to the shadow queues and returns the outcome the
   // block must produce for it.
   task automatic apply_request(input logic op, input logic [DATA_W-1:0] value,
                                output outcome_type outcome);
      bit served;
      bit all_empty;
      outcome = '0;
      outcome.status = (op == REQ_INSERT) ? ST_FULL : ST_EMPTY;
      served = 1'b0;
      for (int k = 0; k < LANES; k++) begin
         if (!served && op == REQ_INSERT && lane_tail[k] < DEPTH) begin
            lane_slots[k][lane_tail[k]] = value;
            lane_tail[k]++;
            outcome.status     = ST_INSERTED;
            outcome.queue_used = QUSED_W'(k);
            served = 1'b1;
         end else if (!served && op == REQ_REMOVE && lane_head[k] < lane_tail[k]) begin
            outcome.value_out = lane_slots[k][lane_head[k]];
            lane_head[k]++;
            outcome.status     = ST_REMOVED;
            outcome.queue_used = QUSED_W'(k);
            served = 1'b1;
         end
      end
      // A removal that leaves everything empty rewinds all pointers.
      if (outcome.status == ST_REMOVED) begin
         all_empty = 1'b1;
         for (int k = 0; k < LANES; k++) begin
            if (lane_head[k] < lane_tail[k]) all_empty = 1'b0;
         end
         if (all_empty) begin
            for (int k = 0; k < LANES; k++) begin
               lane_head[k] = 0;
               lane_tail[k] = 0;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      outcome_type fresh;
      if (reset) begin
         for (int k = 0; k < LANES; k++) begin
            lane_head[k] = 0;
            lane_tail[k] = 0;
         end
         expected_outcomes.delete();
      end else begin
         // A result is registered, so it never belongs to a request taken at this edge.
         if (rsp_tvalid && rsp_tready) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch("without outstanding request", rsp_tdata, '0);
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", rsp_tuser, want.status);
               if (rsp_tdata[31:0] !== want.value_out)
                  report_mismatch("value_out", rsp_tdata[31:0], want.value_out);
               if (rsp_tdata[33:32] !== want.queue_used)
                  report_mismatch("queue_used", rsp_tdata[33:32], want.queue_used);
               if (rsp_tdata[39:34] !== '0)
                  report_mismatch("tdata padding", rsp_tdata[39:34], '0);
            end
         end
         if (req_tvalid && req_tready) begin
            apply_request(req_tuser[0], req_tdata, fresh);
            expected_outcomes.push_back(fresh);
         end
      end
      pending_count <= expected_outcomes.size();
      error_count   <= mismatches;
   end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the queue unit testbench. This module only creates stimulus and
// decides the verdict; the checker beside the block follows every
// transaction on both channels, predicts each result and compares it.
module tb_top
   import tlpq_pkg::*;
();

   // No transaction may be missing for this many cycles in a row. The
   // longest legal quiet stretch is the receiver hold plus one long gap.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TARGET_ITEMS   = 750;
   localparam int LONG_HOLD      = 80;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] value_in
   logic [0:0]  req_tuser  = '0;   // [0] req_type
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [39:0] rsp_tdata;         // [31:0] value_out, [33:32] queue_used, zero above
   wire  [1:0]  rsp_tuser;         // [1:0] status

   int error_count;
   int pending_count;
   int items_sent  = 0;
   int idle_cycles = 0;

   // Shared pacing controls: no_gaps turns off idling on both sides for a
   // stretch, and hold_rsp asks the receiver for one long hold-off.
   bit no_gaps  = 1'b0;
   bit hold_rsp = 1'b0;

   always #5 clock = ~clock;

   three_level_priority_queue_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   tlpq_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // Most gaps are a few cycles; now and then one is long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return $urandom_range(1, 3);
      if (r < 9) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   // Values lean toward the signed and unsigned extremes so that both ends of the range
   // pass through the slot storage often.
   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // Offers one request transaction and returns at the edge that accepted it.
   // When no gap is taken, tvalid simply stays high into the next transaction.
   task automatic send_item(input logic op, input logic [31:0] value);
      int gap;
      gap = (!no_gaps && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tuser[0] <= op;
      req_tdata    <= value;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Stops offering and waits until every expected result has been taken.
   // The first edge is skipped because the count is registered behind the handshake.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Watchdog: ends the run if neither channel moves a transaction for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side. The long hold is counted here so that the sender keeps
   // offering requests meanwhile; the block must then stall its input.
   initial begin : result_side
      int gap_left;
      gap_left = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (gap_left > 0) begin
            rsp_tready <= 1'b0;
            gap_left--;
         end else if (no_gaps || $urandom_range(0, 2) != 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            gap_left = pick_gap() - 1;
         end
      end
   end

   initial begin : request_side
      int segment;
      int count;
      int insert_pct;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: removal from an empty unit, inserts of the extreme
      // values, a removal that empties everything and rewinds the pointers,
      // then a second round that starts again from slot zero.
      send_item(REQ_REMOVE, 32'hFFFF_FFFF);
      send_item(REQ_INSERT, 32'h8000_0000);
      send_item(REQ_INSERT, 32'h7FFF_FFFF);
      send_item(REQ_INSERT, 32'h0000_0000);
      send_item(REQ_INSERT, 32'hFFFF_FFFF);
      repeat (4) send_item(REQ_REMOVE, 32'h0000_0000);
      send_item(REQ_REMOVE, 32'h5555_5555);
      send_item(REQ_INSERT, 32'hAAAA_AAAA);
      send_item(REQ_INSERT, 32'h5555_5555);
      send_item(REQ_REMOVE, 32'hAAAA_AAAA);
      send_item(REQ_INSERT, 32'h1234_5678);
      repeat (3) send_item(REQ_REMOVE, 32'h0000_0000);

      // Random part, built from segments. Fill segments can push past the total
      // capacity, so later queues take over and the full status shows up,
      // then remove a random number of entries. A partial drain leaves the
      // first queue's tail at its end, so it keeps refusing inserts until
      // every queue runs empty. Mixed segments interleave both requests at
      // a chosen insert ratio. The first fill runs right away so that the
      // full case can be met early.
      segment = 0;
      while (items_sent < TARGET_ITEMS) begin
         no_gaps = ($urandom_range(0, 4) == 0);
         if (segment == 3) hold_rsp = 1'b1;
         if (segment == 0 || segment == 3 || $urandom_range(0, 2) == 0) begin
            count = $urandom_range(18, 27);
            repeat (count) send_item(REQ_INSERT, random_word());
            count = $urandom_range(1, 30);
            repeat (count) send_item(REQ_REMOVE, $urandom());
         end else begin
            insert_pct = $urandom_range(1, 3) * 25;
            count      = $urandom_range(10, 40);
            repeat (count) begin
               send_item(($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE,
                         random_word());
            end
         end
         // The sender pauses until the result side has caught up completely.
         if (segment == 6 || $urandom_range(0, 7) == 0) wait_drained();
         segment++;
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
